FILE: design/a2p_pkg.sv
`default_nettype none

package a2p_pkg;

   localparam int INPUT_BITS   = 16;
   localparam int MAG_W        = INPUT_BITS;
   localparam int FRAC_W       = 16;
   localparam int QUO_W        = FRAC_W + 1;
   localparam int NUM_W        = MAG_W + FRAC_W;
   localparam int DIV_STAGES   = QUO_W;
   localparam int SQ_W         = 2 * QUO_W;
   localparam int ACC_W        = 32;
   localparam int OPR_W        = QUO_W + 1;
   localparam int PROD_W       = ACC_W + OPR_W;
   localparam int RND_W        = PROD_W - FRAC_W;
   localparam int HORNER_STEPS = 7;
   localparam int REF_W        = ACC_W + 2;
   localparam int ANGLE_W      = 16;
   localparam int OUT_SHIFT    = 17;
   localparam int LATENCY      = 2 + DIV_STAGES + 2 + 2 * HORNER_STEPS + 2;

   localparam logic [SQ_W-1:0]          SQ_HALF   = SQ_W'(1) << (FRAC_W - 1);
   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_W - 1);
   localparam logic signed [REF_W-1:0]  OUT_HALF  = REF_W'(1) << (OUT_SHIFT - 1);

   localparam logic signed [REF_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [REF_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ANGLE_W-1:0] PI_Q13    = 16'sd25736;
   localparam logic [QUO_W-1:0] ONE_Q16            = QUO_W'(1) << FRAC_W;

   // highest-order coefficient seeds the accumulator
   localparam logic signed [ACC_W-1:0] POLY_SEED = 32'sd7744777;

   // added after each Horner multiply; the last step (times r) adds nothing
   localparam logic signed [ACC_W-1:0] POLY_ADD [HORNER_STEPS] = '{
      -32'sd37645046,
      32'sd87698811,
      -32'sd143609290,
      32'sd213207690,
      -32'sd357824448,
      32'sd1073741824,
      32'sd0
   };

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic y_big;
      logic zero;
   } side_type;

endpackage

`default_nettype wire

FILE: design/atan2_polynomial_core.sv
`default_nettype none

// Fixed-point atan2: angle of vector (x, y) in signed Q3.13 radians, -pi..pi.
// Input: pulse start with req_x_coord / req_y_coord; a beat is taken at every
// rising edge with start high and busy low. busy is always low, so a new
// vector may enter every cycle.
// Output: rsp_strobe is high for one cycle with rsp_angle valid; the receiver
// must take it then, as it cannot hold results off.
// Pipeline, from the accepting edge to the strobe: a magnitude stage and a
// select stage, the ratio division (one quotient bit per stage), a squaring
// stage and a rounding stage for r^2, the seven Horner steps (a multiply
// stage and a round/add stage each), then stages to reflect, round, sign.
// Throughput: one vector per cycle; results leave in arrival order.
// Reset clears every stage's valid bit, so no strobe follows reset until new
// beats arrive; data registers are not reset.
// A zero vector returns 0; x < 0 with y = 0 returns +pi.
module atan2_polynomial_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [a2p_pkg::INPUT_BITS-1:0]  req_x_coord,
   input  wire logic signed [a2p_pkg::INPUT_BITS-1:0]  req_y_coord,
   output logic                                        rsp_strobe,
   output logic signed [a2p_pkg::ANGLE_W-1:0]          rsp_angle
);

   localparam int D = a2p_pkg::DIV_STAGES;
   localparam int H = a2p_pkg::HORNER_STEPS;

   // stage 1: magnitudes
   logic                          s1_vld_ff;
   logic [a2p_pkg::MAG_W-1:0]     s1_ax_ff, s1_ax_in, s1_ay_ff, s1_ay_in;
   a2p_pkg::side_type             s1_side_ff, s1_side_in;

   // stage 2 and divider
   logic [a2p_pkg::MAG_W-1:0]     sel_big, sel_small;
   logic                          sel_y_big;
   logic [a2p_pkg::NUM_W-1:0]     sel_num;
   logic [D:0]                    dv_vld_ff;
   logic [a2p_pkg::MAG_W-1:0]     dv_rem_ff [D+1];
   logic [a2p_pkg::MAG_W-1:0]     dv_rem_in [D+1];
   logic [a2p_pkg::MAG_W-1:0]     dv_big_ff [D+1];
   logic [a2p_pkg::MAG_W-1:0]     dv_big_in [D+1];
   logic [a2p_pkg::QUO_W-1:0]     dv_lo_ff  [D+1];
   logic [a2p_pkg::QUO_W-1:0]     dv_lo_in  [D+1];
   logic [a2p_pkg::QUO_W-1:0]     dv_q_ff   [D+1];
   logic [a2p_pkg::QUO_W-1:0]     dv_q_in   [D+1];
   a2p_pkg::side_type             dv_side_ff [D+1];
   a2p_pkg::side_type             dv_side_in [D+1];
   logic [a2p_pkg::MAG_W:0]       dv_trial  [D+1];
   logic                          dv_ge     [D+1];

   // squaring
   logic                          sq_vld_ff;
   logic [a2p_pkg::QUO_W-1:0]     sq_r_ff;
   logic [a2p_pkg::SQ_W-1:0]      sq_prod_ff, sq_prod_in, sq_sum;
   a2p_pkg::side_type             sq_side_ff;
   logic                          r2_vld_ff;
   logic [a2p_pkg::QUO_W-1:0]     r2_r_ff, r2_sq_ff, r2_sq_in;
   a2p_pkg::side_type             r2_side_ff;

   // Horner steps
   logic [H-1:0]                  hm_vld_ff, ha_vld_ff;
   logic signed [a2p_pkg::ACC_W-1:0]  hm_acc_src [H];
   logic signed [a2p_pkg::OPR_W-1:0]  hm_opr     [H];
   logic signed [a2p_pkg::PROD_W-1:0] hm_prod_ff [H];
   logic signed [a2p_pkg::PROD_W-1:0] hm_prod_in [H];
   logic signed [a2p_pkg::PROD_W-1:0] ha_rnd     [H];
   logic signed [a2p_pkg::ACC_W-1:0]  ha_acc_ff  [H];
   logic signed [a2p_pkg::ACC_W-1:0]  ha_acc_in  [H];
   logic [a2p_pkg::QUO_W-1:0]     hm_r_ff [H], hm_r2_ff [H], ha_r_ff [H], ha_r2_ff [H];
   a2p_pkg::side_type             hm_side_ff [H], ha_side_ff [H];
   logic [a2p_pkg::QUO_W-1:0]     hm_r_in [H], hm_r2_in [H];
   a2p_pkg::side_type             hm_side_in [H];

   // reflect and output
   logic                          rf_vld_ff;
   logic signed [a2p_pkg::REF_W-1:0] rf_base, rf_val_ff, rf_val_in;
   a2p_pkg::side_type             rf_side_ff;
   logic signed [a2p_pkg::REF_W-1:0] out_clamp, out_sum;
   logic [a2p_pkg::ANGLE_W-1:0]   out_mag;
   logic                          rsp_strobe_ff;
   logic signed [a2p_pkg::ANGLE_W-1:0] rsp_angle_ff, rsp_angle_in;

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_angle  = rsp_angle_ff;

   always_comb begin
      s1_side_in       = '0;
      s1_side_in.x_neg = req_x_coord[a2p_pkg::INPUT_BITS-1];
      s1_side_in.y_neg = req_y_coord[a2p_pkg::INPUT_BITS-1];
      s1_ax_in = s1_side_in.x_neg ? (~$unsigned(req_x_coord)) + a2p_pkg::MAG_W'(1)
                                  : $unsigned(req_x_coord);
      s1_ay_in = s1_side_in.y_neg ? (~$unsigned(req_y_coord)) + a2p_pkg::MAG_W'(1)
                                  : $unsigned(req_y_coord);
   end

   always_comb begin
      sel_y_big = s1_ay_ff > s1_ax_ff;
      sel_big   = sel_y_big ? s1_ay_ff : s1_ax_ff;
      sel_small = sel_y_big ? s1_ax_ff : s1_ay_ff;
      sel_num   = {sel_small, a2p_pkg::FRAC_W'(0)} + a2p_pkg::NUM_W'(sel_big >> 1);

      dv_trial[0]         = '0;
      dv_ge[0]            = 1'b0;
      dv_rem_in[0]        = {1'b0, sel_num[a2p_pkg::NUM_W-1:a2p_pkg::QUO_W]};
      dv_lo_in[0]         = sel_num[a2p_pkg::QUO_W-1:0];
      dv_big_in[0]        = sel_big;
      dv_q_in[0]          = '0;
      dv_side_in[0]       = s1_side_ff;
      dv_side_in[0].y_big = sel_y_big;
      dv_side_in[0].zero  = (sel_big == '0);

      for (int k = 1; k <= D; k++) begin
         dv_trial[k]   = {dv_rem_ff[k-1], dv_lo_ff[k-1][a2p_pkg::QUO_W-k]};
         dv_ge[k]      = dv_trial[k] >= {1'b0, dv_big_ff[k-1]};
         dv_rem_in[k]  = dv_ge[k] ? a2p_pkg::MAG_W'(dv_trial[k] - {1'b0, dv_big_ff[k-1]})
                                  : a2p_pkg::MAG_W'(dv_trial[k]);
         dv_q_in[k]    = {dv_q_ff[k-1][a2p_pkg::QUO_W-2:0], dv_ge[k]};
         dv_lo_in[k]   = dv_lo_ff[k-1];
         dv_big_in[k]  = dv_big_ff[k-1];
         dv_side_in[k] = dv_side_ff[k-1];
      end
   end

   always_comb begin
      sq_prod_in = a2p_pkg::SQ_W'(dv_q_ff[D]) * a2p_pkg::SQ_W'(dv_q_ff[D]);
      sq_sum     = sq_prod_ff + a2p_pkg::SQ_HALF;
      r2_sq_in   = sq_sum[a2p_pkg::FRAC_W+a2p_pkg::QUO_W-1:a2p_pkg::FRAC_W];
   end

   always_comb begin
      hm_acc_src[0] = a2p_pkg::POLY_SEED;
      hm_r_in[0]    = r2_r_ff;
      hm_r2_in[0]   = r2_sq_ff;
      hm_side_in[0] = r2_side_ff;
      for (int k = 1; k < H; k++) begin
         hm_acc_src[k] = ha_acc_ff[k-1];
         hm_r_in[k]    = ha_r_ff[k-1];
         hm_r2_in[k]   = ha_r2_ff[k-1];
         hm_side_in[k] = ha_side_ff[k-1];
      end
      for (int k = 0; k < H; k++) begin
         // last step multiplies by r, the others by r^2
         hm_opr[k]     = (k < H - 1) ? $signed({1'b0, hm_r2_in[k]})
                                     : $signed({1'b0, hm_r_in[k]});
         hm_prod_in[k] = a2p_pkg::PROD_W'(hm_acc_src[k]) * a2p_pkg::PROD_W'(hm_opr[k]);
         ha_rnd[k]     = hm_prod_ff[k] + a2p_pkg::PROD_HALF;
         ha_acc_in[k]  = a2p_pkg::ACC_W'($signed(ha_rnd[k][a2p_pkg::PROD_W-1:a2p_pkg::FRAC_W])
                                       + a2p_pkg::RND_W'(a2p_pkg::POLY_ADD[k]));
      end
   end

   always_comb begin
      rf_base = a2p_pkg::REF_W'(ha_acc_ff[H-1]);
      if (ha_side_ff[H-1].y_big && ha_side_ff[H-1].x_neg) begin
         rf_val_in = a2p_pkg::HALF_PI_Q30 + rf_base;
      end else if (ha_side_ff[H-1].y_big) begin
         rf_val_in = a2p_pkg::HALF_PI_Q30 - rf_base;
      end else if (ha_side_ff[H-1].x_neg) begin
         rf_val_in = a2p_pkg::PI_Q30 - rf_base;
      end else begin
         rf_val_in = rf_base;
      end
   end

   always_comb begin
      if (rf_val_ff < 0) begin
         out_clamp = '0;
      end else if (rf_val_ff > a2p_pkg::PI_Q30) begin
         out_clamp = a2p_pkg::PI_Q30;
      end else begin
         out_clamp = rf_val_ff;
      end
      out_sum = out_clamp + a2p_pkg::OUT_HALF;
      out_mag = out_sum[a2p_pkg::OUT_SHIFT+a2p_pkg::ANGLE_W-1:a2p_pkg::OUT_SHIFT];
      if (rf_side_ff.zero) begin
         rsp_angle_in = '0;
      end else if (rf_side_ff.y_neg) begin
         rsp_angle_in = $signed(~out_mag + a2p_pkg::ANGLE_W'(1));
      end else begin
         rsp_angle_in = $signed(out_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         dv_vld_ff     <= '0;
         sq_vld_ff     <= 1'b0;
         r2_vld_ff     <= 1'b0;
         hm_vld_ff     <= '0;
         ha_vld_ff     <= '0;
         rf_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_vld_ff     <= start && !busy;
         dv_vld_ff     <= {dv_vld_ff[D-1:0], s1_vld_ff};
         sq_vld_ff     <= dv_vld_ff[D];
         r2_vld_ff     <= sq_vld_ff;
         hm_vld_ff     <= {ha_vld_ff[H-2:0], r2_vld_ff};
         ha_vld_ff     <= hm_vld_ff;
         rf_vld_ff     <= ha_vld_ff[H-1];
         rsp_strobe_ff <= rf_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ax_ff   <= s1_ax_in;
      s1_ay_ff   <= s1_ay_in;
      s1_side_ff <= s1_side_in;
      for (int k = 0; k <= D; k++) begin
         dv_rem_ff[k]  <= dv_rem_in[k];
         dv_big_ff[k]  <= dv_big_in[k];
         dv_lo_ff[k]   <= dv_lo_in[k];
         dv_q_ff[k]    <= dv_q_in[k];
         dv_side_ff[k] <= dv_side_in[k];
      end
      sq_r_ff    <= dv_q_ff[D];
      sq_prod_ff <= sq_prod_in;
      sq_side_ff <= dv_side_ff[D];
      r2_r_ff    <= sq_r_ff;
      r2_sq_ff   <= r2_sq_in;
      r2_side_ff <= sq_side_ff;
      for (int k = 0; k < H; k++) begin
         hm_prod_ff[k] <= hm_prod_in[k];
         hm_r_ff[k]    <= hm_r_in[k];
         hm_r2_ff[k]   <= hm_r2_in[k];
         hm_side_ff[k] <= hm_side_in[k];
         ha_acc_ff[k]  <= ha_acc_in[k];
         ha_r_ff[k]    <= hm_r_ff[k];
         ha_r2_ff[k]   <= hm_r2_ff[k];
         ha_side_ff[k] <= hm_side_ff[k];
      end
      rf_val_ff    <= rf_val_in;
      rf_side_ff   <= ha_side_ff[H-1];
      rsp_angle_ff <= rsp_angle_in;
   end

   a_ratio_bound: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff && !sq_side_ff.zero |-> sq_r_ff <= a2p_pkg::ONE_Q16)
      else $error("ratio above one");

   a_r2_bound: assert property (@(posedge clock) disable iff (reset)
      r2_vld_ff && !r2_side_ff.zero |-> r2_sq_ff <= a2p_pkg::ONE_Q16)
      else $error("squared ratio above one");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_angle <= a2p_pkg::PI_Q13 && rsp_angle >= -a2p_pkg::PI_Q13)
      else $error("angle out of range");

   a_angle_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(rf_side_ff.y_neg) || !rsp_angle[a2p_pkg::ANGLE_W-1])
      else $error("negative angle for y >= 0");

   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rf_vld_ff && rf_side_ff.zero |=> rsp_strobe && rsp_angle == '0)
      else $error("zero vector gave nonzero angle");

   a_strobe_order: assert property (@(posedge clock) disable iff (reset)
      rf_vld_ff |-> $past(ha_vld_ff[H-1]))
      else $error("reflect stage valid without Horner result");

endmodule

`default_nettype wire
